// ===== design/b64d_pkg.sv =====
`timescale 1ns / 1ps

package b64d_pkg;

    localparam logic [7:0] PAD_CODE = 8'd61;

    typedef logic [1:0] t_phase;
    typedef logic [5:0] t_sextet;

    typedef struct packed {
        logic [7:0] char_code;
        logic       message_last;
    } t_char_beat;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       message_end;
        logic       pad_seen;
    } t_byte_beat;

    typedef struct packed {
        logic       hit;
        t_sextet    value;
    } t_sextet_res;

    // Maps one character to its 6-bit value; hit is low outside the alphabet.
    function automatic t_sextet_res sextet_of(input logic [7:0] c);
        t_sextet_res r;
        r.hit   = 1'b1;
        r.value = '0;
        case (c) inside
            [8'h41:8'h5A]: r.value = 6'(c - 8'h41);
            [8'h61:8'h7A]: r.value = 6'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]: r.value = 6'(c - 8'h30 + 8'd52);
            8'h2B:         r.value = 6'd62;
            8'h2F:         r.value = 6'd63;
            default:       r.hit   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/b64d_char_if.sv =====
`timescale 1ns / 1ps

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       message_last;

    modport source (output valid, output char_code, output message_last, input ready);
    modport sink   (input valid, input char_code, input message_last, output ready);
endinterface

// ===== design/b64d_byte_if.sv =====
`timescale 1ns / 1ps

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       message_end;
    logic       pad_seen;

    modport source (
        output valid, output byte_valid, output data_byte,
        output message_end, output pad_seen, input ready
    );
    modport sink (
        input valid, input byte_valid, input data_byte,
        input message_end, input pad_seen, output ready
    );
endinterface

// ===== design/base64_stream_decoder_core.sv =====
// An accepted character passes the input register, then the result register.
// Throughput: one character per cycle while the output is not stalled; the decode state updates once per beat
// as it moves from the input register into the result register.
// Reset: synchronous, active low; clears both stage valids, the group phase,
// the held sextet and the padding stop flag.
`timescale 1ns / 1ps

module base64_stream_decoder_core
    import b64d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    b64d_char_if.sink   i_char,
    b64d_byte_if.source o_byte
);

    t_char_beat in_beat;
    t_char_beat stage_beat;
    t_byte_beat out_beat;
    logic       stage_valid;
    logic       take;

    assign in_beat.char_code    = i_char.char_code;
    assign in_beat.message_last = i_char.message_last;

    b64d_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_char.valid),
        .o_ready (i_char.ready),
        .i_beat  (in_beat),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_beat  (stage_beat)
    );

    b64d_dec_stage u_dec_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_beat      (stage_beat),
        .o_take      (take),
        .i_out_ready (o_byte.ready),
        .o_out_valid (o_byte.valid),
        .o_out_beat  (out_beat)
    );

    assign o_byte.byte_valid  = out_beat.byte_valid;
    assign o_byte.data_byte   = out_beat.data_byte;
    assign o_byte.message_end = out_beat.message_end;
    assign o_byte.pad_seen    = out_beat.pad_seen;

`ifndef SYNTHESIS
    a_byte_not_after_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && o_byte.byte_valid) |-> !o_byte.pad_seen)
        else $error("decoded byte delivered while padding stop is flagged");

    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && !o_byte.byte_valid) |-> (o_byte.data_byte == 8'd0))
        else $error("data byte not zero on a beat without a byte");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_byte.valid |-> i_char.ready)
        else $error("input stalled while the result register is empty");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && !o_byte.valid) |=> o_byte.valid)
        else $error("held character did not reach the result register");
`endif

endmodule

// ===== design/b64d_in_stage.sv =====
`timescale 1ns / 1ps

module b64d_in_stage
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_char_beat i_beat,
    input  logic       i_take,
    output logic       o_valid,
    output t_char_beat o_beat
);

    logic       r_valid;
    t_char_beat r_beat;

    // The register frees up in the same cycle that the decode stage takes its beat.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

// ===== design/b64d_dec_stage.sv =====
`timescale 1ns / 1ps

module b64d_dec_stage
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_char_beat i_beat,
    output logic       o_take,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_byte_beat o_out_beat
);

    logic        r_out_valid;
    t_byte_beat  r_out_beat;
    t_phase      r_phase;
    t_sextet     r_held;
    logic        r_stopped;

    t_phase      n_phase;
    t_sextet     n_held;
    logic        n_stopped;
    t_byte_beat  n_out_beat;
    t_sextet_res lut;
    logic [7:0]  byte_val;
    logic        byte_hit;

    assign o_take      = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;
    assign lut         = sextet_of(i_beat.char_code);

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_stopped = r_stopped;
        byte_hit  = 1'b0;
        byte_val  = '0;
        if (!r_stopped) begin
            if (i_beat.char_code == PAD_CODE && r_phase[1]) begin
                n_stopped = 1'b1;
            end else if (lut.hit) begin
                case (r_phase)
                    2'd1:    byte_val = {r_held, lut.value[5:4]};
                    2'd2:    byte_val = {r_held[3:0], lut.value[5:2]};
                    2'd3:    byte_val = {r_held[1:0], lut.value};
                    default: byte_val = '0;
                endcase
                byte_hit = (r_phase != 2'd0);
                n_held   = lut.value;
                n_phase  = r_phase + 2'd1;
            end
        end
        n_out_beat.byte_valid  = byte_hit;
        n_out_beat.data_byte   = byte_val;
        n_out_beat.message_end = i_beat.message_last;
        n_out_beat.pad_seen    = n_stopped;
        // The last character of a message leaves the decoder ready for a new one.
        if (i_beat.message_last) begin
            n_phase   = '0;
            n_held    = '0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_held      <= '0;
            r_stopped   <= 1'b0;
        end else begin
            if (o_take) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_held      <= n_held;
                r_stopped   <= n_stopped;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take) begin
            r_out_beat <= n_out_beat;
        end
    end

endmodule
